@@ sv/analog_scale_filter_hysteresis_macros.svh @@
// Assertion helpers used by the checker file of this block.
`ifndef ANALOG_SCALE_FILTER_HYSTERESIS_MACROS_SVH
`define ANALOG_SCALE_FILTER_HYSTERESIS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASFH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASFH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/asfh_pkg.sv @@
`timescale 1ns / 1ps

package asfh_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Filter weight is unsigned Q1.16 regardless of the value format
	localparam int WEIGHT_SHIFT = 16;
	localparam logic [16:0] WEIGHT_ONE = 17'h10000;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_MIN,
		REG_SCALE_MAX,
		REG_SCALE_GAIN,
		REG_SCALE_OFFSET,
		REG_VALUE_TRIM,
		REG_COUNT_TRIM,
		REG_FILTER_WEIGHT,
		REG_HYSTERESIS_BAND
	} asfh_reg_t;

	// Register file contents
	typedef struct packed {
		logic [31:0] scale_min;
		logic [31:0] scale_max;
		logic [31:0] scale_gain;
		logic [31:0] scale_offset;
		logic [31:0] value_trim;
		logic [12:0] count_trim;
		logic [16:0] filter_weight;
		logic [30:0] hysteresis_band;
	} asfh_cfg_t;

	// Control of the shift-add multiplier
	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} asfh_mul_ctrl_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_OFFSET,
		ST_TRIM,
		ST_CLAMP_HI,
		ST_CLAMP_LO,
		ST_DELTA_X,
		ST_MUL2,
		ST_FILTER,
		ST_DELTA_Y,
		ST_EMIT
	} asfh_state_t;

endpackage

@@ sv/asfh_cfg_regs.sv @@
`timescale 1ns / 1ps

module asfh_cfg_regs #(
	parameter int SAMPLE_BITS   = 12,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [asfh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [asfh_pkg::CFG_DATA_W-1:0] cfg_data,
	output asfh_pkg::asfh_cfg_t           cfg
);
	import asfh_pkg::*;

	// Reset values follow the sample and fraction widths
	localparam logic [63:0] MAX_RST  = ((64'd1 << SAMPLE_BITS) - 64'd1) << FRACTION_BITS;
	localparam logic [63:0] GAIN_RST = 64'd1 << FRACTION_BITS;

	asfh_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_min       <= '0;
			cfg_q.scale_max       <= MAX_RST[31:0];
			cfg_q.scale_gain      <= GAIN_RST[31:0];
			cfg_q.scale_offset    <= '0;
			cfg_q.value_trim      <= '0;
			cfg_q.count_trim      <= '0;
			cfg_q.filter_weight   <= WEIGHT_ONE;
			cfg_q.hysteresis_band <= 31'h0001_0000;
		end else if (cfg_wr_en) begin
			unique case (asfh_reg_t'(cfg_index))
				REG_SCALE_MIN:       cfg_q.scale_min       <= cfg_data;
				REG_SCALE_MAX:       cfg_q.scale_max       <= cfg_data;
				REG_SCALE_GAIN:      cfg_q.scale_gain      <= cfg_data;
				REG_SCALE_OFFSET:    cfg_q.scale_offset    <= cfg_data;
				REG_VALUE_TRIM:      cfg_q.value_trim      <= cfg_data;
				REG_COUNT_TRIM:      cfg_q.count_trim      <= cfg_data[12:0];
				REG_FILTER_WEIGHT:   cfg_q.filter_weight   <= cfg_data[16:0];
				REG_HYSTERESIS_BAND: cfg_q.hysteresis_band <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/asfh_serial_mul.sv @@
`timescale 1ns / 1ps

// Signed shift-add multiplier, one multiplier bit per cycle while step is asserted, LSB first.
// The last step handles the sign bit of the multiplier by subtracting.
module asfh_serial_mul #(
	parameter int AW = 33,
	parameter int BW = 18
) (
	input  logic                       clk,
	input  asfh_pkg::asfh_mul_ctrl_t   ctrl,
	input  logic signed [AW-1:0]       a,
	input  logic signed [BW-1:0]       b,
	output logic signed [AW+BW-1:0]    prod
);
	import asfh_pkg::*;

	logic signed [AW-1:0] a_q;
	logic signed [AW:0]   hi_q;
	logic        [BW-1:0] lo_q;
	logic signed [AW:0]   a_sx;
	logic signed [AW:0]   partial;
	logic signed [AW:0]   sum;

	// Partial product for the current multiplier bit
	always_comb begin
		a_sx    = {a_q[AW-1], a_q};
		partial = '0;
		if (lo_q[0])
			partial = ctrl.last ? -a_sx : a_sx;
		sum = hi_q + partial;
	end

	// Accumulate and shift right one place per step
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (ctrl.step) begin
			hi_q <= {sum[AW], sum[AW:1]};
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign prod = {hi_q[AW-1:0], lo_q};

endmodule

@@ sv/analog_scale_filter_hysteresis.sv @@
`timescale 1ns / 1ps

// ADC sample conditioning: trim, linear scale, clamp, first-order filter and
// hysteresis change detection, all in signed Q16.16.
//
// Input channel (in_valid / in_stall) carries adc_sample; a transaction
// completes when in_valid is high and in_stall low. Output channel
// (out_valid / out_stall) carries filtered_value, magnitude, negative and
// variation, one result per input. Registers are written through cfg_wr_en,
// cfg_index and cfg_data; the user must do so only while no transaction is
// in flight, as the block does not enforce it.
//
// One sample at a time runs through a bit-serial shift-add multiplier, used
// twice (gain times count, then weight times filter step), with a multiplier
// operand of BW = max(18, SAMPLE_BITS + 2) bits. The result sits in an
// output register; while the receiver stalls it holds, and a finished
// sample waits in the last step until the register frees up. Reset
// restores the register defaults and clears the filter memory, the
// hysteresis reference and the variation flag.
module analog_scale_filter_hysteresis #(
	parameter int SAMPLE_BITS   = 12,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [asfh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [asfh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [SAMPLE_BITS-1:0]          adc_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              filtered_value,
	output logic [31:0]                     magnitude,
	output logic                            negative,
	output logic                            variation
);
	import asfh_pkg::*;

	// Operand widths of the shared multiplier
	localparam int AW    = 33;
	localparam int BW    = (SAMPLE_BITS + 2 > 18) ? SAMPLE_BITS + 2 : 18;
	localparam int XW    = AW + BW;
	localparam int CNT_W = $clog2(BW);

	asfh_cfg_t      cfg;
	asfh_mul_ctrl_t mul_ctrl;
	asfh_state_t    state_q, state_d;

	logic [CNT_W-1:0]       cnt_q;
	logic signed [AW-1:0]   mul_a;
	logic signed [BW-1:0]   mul_b;
	logic signed [XW-1:0]   prod;

	logic signed [XW-1:0]   x_q;
	logic signed [31:0]     m_q;
	logic signed [31:0]     ref_q;
	logic                   flag_q;
	logic signed [31:0]     y_q;
	logic signed [32:0]     delta_q;

	logic                   out_valid_q;
	logic signed [31:0]     filtered_value_q;
	logic [31:0]            magnitude_q;
	logic                   negative_q;
	logic                   variation_q;

	logic                   accept;
	logic                   out_free;
	logic                   emit;
	logic                   cnt_last;

	logic signed [BW-1:0]   count_b;
	logic signed [AW-1:0]   gain_a;
	logic signed [AW-1:0]   step_a;
	logic signed [BW-1:0]   weight_b;
	logic [16:0]            weight_sat;
	logic signed [XW-1:0]   offset_x, trim_x, min_x, max_x;
	logic signed [32:0]     y_sum;
	logic signed [33:0]     delta_w, band_w;
	logic                   crossing;

	asfh_cfg_regs #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	asfh_serial_mul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk (clk),
		.ctrl(mul_ctrl),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	// Handshake helpers
	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign out_free = !out_valid_q || !out_stall;
	assign cnt_last = (cnt_q == '0);

	// Operand preparation
	always_comb begin
		count_b    = {{(BW-SAMPLE_BITS){1'b0}}, adc_sample}
		           + {{(BW-13){cfg.count_trim[12]}}, cfg.count_trim};
		gain_a     = {cfg.scale_gain[31], cfg.scale_gain};
		step_a     = {x_q[31], x_q[31:0]} - {m_q[31], m_q};
		weight_sat = cfg.filter_weight[16] ? WEIGHT_ONE : cfg.filter_weight;
		weight_b   = {{(BW-17){1'b0}}, weight_sat};
		offset_x   = {{(XW-32){cfg.scale_offset[31]}}, cfg.scale_offset};
		trim_x     = {{(XW-32){cfg.value_trim[31]}}, cfg.value_trim};
		min_x      = {{(XW-32){cfg.scale_min[31]}}, cfg.scale_min};
		max_x      = {{(XW-32){cfg.scale_max[31]}}, cfg.scale_max};
		y_sum      = {m_q[31], m_q} + prod[WEIGHT_SHIFT+32:WEIGHT_SHIFT];
		delta_w    = {delta_q[32], delta_q};
		band_w     = {3'b000, cfg.hysteresis_band};
		crossing   = (delta_w >= band_w) || (delta_w <= -band_w);
		mul_a      = (state_q == ST_IDLE) ? gain_a : step_a;
		mul_b      = (state_q == ST_IDLE) ? count_b : weight_b;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_MUL1;
			ST_MUL1:     if (cnt_last) state_d = ST_OFFSET;
			ST_OFFSET:   state_d = ST_TRIM;
			ST_TRIM:     state_d = ST_CLAMP_HI;
			ST_CLAMP_HI: state_d = ST_CLAMP_LO;
			ST_CLAMP_LO: state_d = ST_DELTA_X;
			ST_DELTA_X:  state_d = ST_MUL2;
			ST_MUL2:     if (cnt_last) state_d = ST_FILTER;
			ST_FILTER:   state_d = ST_DELTA_Y;
			ST_DELTA_Y:  state_d = ST_EMIT;
			ST_EMIT:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		mul_ctrl.load = accept || (state_q == ST_DELTA_X);
		mul_ctrl.step = (state_q == ST_MUL1) || (state_q == ST_MUL2);
		mul_ctrl.last = cnt_last;
		emit          = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (mul_ctrl.load)
				cnt_q <= CNT_W'(BW - 1);
			else if (mul_ctrl.step)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Scaling, trim, clamp, filter and delta datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_OFFSET:   x_q <= prod + offset_x;
			ST_TRIM:     x_q <= x_q + trim_x;
			ST_CLAMP_HI: if (x_q > max_x) x_q <= max_x;
			ST_CLAMP_LO: if (x_q < min_x) x_q <= min_x;
			ST_FILTER:   y_q <= y_sum[31:0];
			ST_DELTA_Y:  delta_q <= {y_q[31], y_q} - {ref_q[31], ref_q};
			default: ;
		endcase
	end

	// Filter memory, hysteresis reference and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q    <= '0;
			ref_q  <= '0;
			flag_q <= 1'b0;
		end else if (emit) begin
			m_q <= y_q;
			if (crossing) begin
				ref_q  <= y_q;
				flag_q <= !flag_q;
			end else begin
				flag_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			filtered_value_q <= y_q;
			magnitude_q      <= y_q[31] ? 32'(-y_q) : y_q;
			negative_q       <= y_q[31];
			variation_q      <= crossing ? !flag_q : 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = filtered_value_q;
	assign magnitude      = magnitude_q;
	assign negative       = negative_q;
	assign variation      = variation_q;

endmodule

@@ sv/asfh_checker.sv @@
`timescale 1ns / 1ps

`include "analog_scale_filter_hysteresis_macros.svh"

module asfh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] filtered_value,
	input logic [31:0] magnitude,
	input logic        negative,
	input logic        variation
);

	// Sign and magnitude agree with the filtered value
	`ASFH_ASSERT_IMP(a_mag_sign, clk, arst_n, out_valid, (negative == filtered_value[31]) && (magnitude == (negative ? (32'd0 - filtered_value) : filtered_value)), "magnitude or sign inconsistent")

	// One sample in flight: input stalls right after a transaction
	`ASFH_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while busy")

	// No result can appear the cycle after a sample is taken
	`ASFH_ASSERT_NXT(a_min_latency, clk, arst_n, in_valid && !in_stall, !$rose(out_valid), "result too early")

	// A stalled result holds
	`ASFH_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(filtered_value) && $stable(variation), "stalled result changed")

endmodule

bind analog_scale_filter_hysteresis asfh_checker u_asfh_checker (.*);
